[design/mi3_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse and determinant block.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int ElemW      = 16;   // Q8.8 matrix entry
  localparam int ProdW      = 32;   // Q16.16 product of two entries
  localparam int AdjW       = 33;   // Q17.16 cofactor
  localparam int DetW       = 49;   // Q25.24 determinant
  localparam int DmagW      = 48;   // magnitude of the determinant
  localparam int NmagW      = 32;   // magnitude of a cofactor
  localparam int QuoW       = 32;   // quotient bits produced per lane
  localparam int NumElem    = 9;
  localparam int FeStages   = 5;    // cofactor and determinant front end
  localparam int DivStages  = QuoW + 1;
  localparam int PipeStages = FeStages + DivStages;
  localparam int InTdataW   = NumElem * ElemW;
  localparam int OutBits    = NumElem * QuoW + DetW;
  localparam int OutTdataW  = ((OutBits + 7) / 8) * 8;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AdjW-1:0]  adj_t;
  typedef logic signed [DetW-1:0]  det_t;

  typedef struct packed {
    logic [QuoW-1:0] quo;  // magnitude of the quotient, low 32 bits
    logic            ovf;  // quotient magnitude reached 2^32 (or divisor zero)
    logic            neg;  // quotient is negative
  } lane_res_t;

endpackage

[design/matrix3_inverse_determinant_top.sv]
// Top level of the 3x3 matrix inverse and determinant block.
// An accepted input transaction goes through the front end, divider lanes and output register.
// Throughput: one matrix per cycle when en is high; divider lanes and front end fully pipelined.
// Each of the nine divider lanes produces one quotient bit per stage.
// Reset (rst_n low, synchronous) clears only the valid bits; data registers are not reset.
// A two-deep output register and skid pair lets input continue while a result waits.
`timescale 1ns / 1ps
module matrix3_inverse_determinant_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata, from bit 0 up: in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1,
  // in_r1c2, in_r2c0, in_r2c1, in_r2c2 (16 bits each, signed Q8.8).
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mi3_pkg::InTdataW-1:0]  in_tdata,
  // out_tdata, from bit 0 up: inv_r0c0 .. inv_r2c2 (32 bits each, Q16.16),
  // determinant (49 bits, Q25.24), then zero padding to a whole byte.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mi3_pkg::OutTdataW-1:0] out_tdata,
  // out_tuser: singular (high when the determinant is zero).
  output logic                          out_tuser
);

  // The whole pipeline advances together whenever the skid register is empty.
  logic                       en;
  mi3_pkg::elem_t             a_in   [mi3_pkg::NumElem];
  mi3_pkg::adj_t              adj    [mi3_pkg::NumElem];
  mi3_pkg::det_t              det;
  mi3_pkg::lane_res_t         lane   [mi3_pkg::NumElem];
  logic [mi3_pkg::PipeStages-1:0] vld_r;
  mi3_pkg::det_t              detd_r [mi3_pkg::DivStages];

  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < mi3_pkg::NumElem; k++) begin
      a_in[k] = in_tdata[k*mi3_pkg::ElemW +: mi3_pkg::ElemW];
    end
  end

  mi3_front u_front (
    .clk     (clk),
    .en      (en),
    .a_in    (a_in),
    .adj_out (adj),
    .det_out (det)
  );

  for (genvar g = 0; g < mi3_pkg::NumElem; g++) begin : g_lane
    mi3_div_lane u_lane (
      .clk    (clk),
      .en     (en),
      .adj_in (adj[g]),
      .det_in (det),
      .res    (lane[g])
    );
  end

  // Valid bits track each transaction; the determinant rides alongside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[mi3_pkg::PipeStages-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      detd_r[0] <= det;
      for (int k = 1; k < mi3_pkg::DivStages; k++) begin
        detd_r[k] <= detd_r[k-1];
      end
    end
  end

  mi3_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_in     (vld_r[mi3_pkg::PipeStages-1]),
    .lane_in    (lane),
    .det_in     (detd_r[mi3_pkg::DivStages-1]),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[design/mi3_front.sv]
// Cofactor and determinant front end: products, cofactors, then column-0 expansion.
`timescale 1ns / 1ps
module mi3_front (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::elem_t a_in   [mi3_pkg::NumElem],
  output mi3_pkg::adj_t  adj_out[mi3_pkg::NumElem],
  output mi3_pkg::det_t  det_out
);

  // Operand indices of each cofactor: adj = a[L1]*a[L2] - a[R1]*a[R2].
  localparam int L1 [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int L2 [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int R1 [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int R2 [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};

  mi3_pkg::elem_t a_r    [mi3_pkg::NumElem];
  mi3_pkg::prod_t pl_r   [mi3_pkg::NumElem];
  mi3_pkg::prod_t pr_r   [mi3_pkg::NumElem];
  mi3_pkg::elem_t c2_r   [3];
  mi3_pkg::elem_t c3_r   [3];
  mi3_pkg::adj_t  adj3_r [mi3_pkg::NumElem];
  mi3_pkg::adj_t  adj4_r [mi3_pkg::NumElem];
  mi3_pkg::adj_t  adj5_r [mi3_pkg::NumElem];
  mi3_pkg::det_t  dp_r   [3];
  mi3_pkg::det_t  det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::NumElem; k++) begin
        a_r[k]    <= a_in[k];
        pl_r[k]   <= a_r[L1[k]] * a_r[L2[k]];
        pr_r[k]   <= a_r[R1[k]] * a_r[R2[k]];
        adj3_r[k] <= mi3_pkg::AdjW'(pl_r[k]) - mi3_pkg::AdjW'(pr_r[k]);
        adj4_r[k] <= adj3_r[k];
        adj5_r[k] <= adj4_r[k];
      end
      for (int c = 0; c < 3; c++) begin
        c2_r[c] <= a_r[3 * c];
        c3_r[c] <= c2_r[c];
        dp_r[c] <= c3_r[c] * adj3_r[c];
      end
      det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    end
  end

  assign adj_out = adj5_r;
  assign det_out = det_r;

endmodule

[design/mi3_div_lane.sv]
// One divider lane: restoring division of |cofactor| * 2^24 by |det|, one bit per stage.
`timescale 1ns / 1ps
module mi3_div_lane (
  input  logic               clk,
  input  logic               en,
  input  mi3_pkg::adj_t      adj_in,
  input  mi3_pkg::det_t      det_in,
  output mi3_pkg::lane_res_t res
);

  localparam int Q = mi3_pkg::QuoW;

  logic [mi3_pkg::DmagW-1:0] rem_r  [Q+1];
  logic [mi3_pkg::DmagW-1:0] rem_nxt[Q+1];
  logic [Q-1:0]              nlo_r  [Q+1];
  logic [Q-1:0]              quo_r  [Q+1];
  logic [Q-1:0]              quo_nxt[Q+1];
  logic [mi3_pkg::DmagW-1:0] d_r    [Q+1];
  logic                      ovf_r  [Q+1];
  logic                      neg_r  [Q+1];

  mi3_pkg::det_t             det_abs;
  mi3_pkg::adj_t             adj_abs;
  logic [mi3_pkg::DmagW-1:0] dmag;
  logic [mi3_pkg::NmagW-1:0] nmag;

  always_comb begin
    det_abs = det_in[mi3_pkg::DetW-1] ? -det_in : det_in;
    adj_abs = adj_in[mi3_pkg::AdjW-1] ? -adj_in : adj_in;
    dmag    = det_abs[mi3_pkg::DmagW-1:0];
    nmag    = adj_abs[mi3_pkg::NmagW-1:0];
  end

  // Each stage shifts in one numerator bit and subtracts the divisor if it fits.
  always_comb begin
    logic [mi3_pkg::DmagW:0] t;
    rem_nxt[0] = '0;
    quo_nxt[0] = '0;
    for (int k = 1; k <= Q; k++) begin
      t = {rem_r[k-1], nlo_r[k-1][Q-1]};
      if (t >= {1'b0, d_r[k-1]}) begin
        t          = t - {1'b0, d_r[k-1]};
        quo_nxt[k] = {quo_r[k-1][Q-2:0], 1'b1};
      end else begin
        quo_nxt[k] = {quo_r[k-1][Q-2:0], 1'b0};
      end
      rem_nxt[k] = t[mi3_pkg::DmagW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The integer part above bit 32 must stay below the divisor, else it saturates.
      rem_r[0] <= mi3_pkg::DmagW'(nmag[mi3_pkg::NmagW-1:8]);
      nlo_r[0] <= {nmag[7:0], 24'd0};
      quo_r[0] <= '0;
      d_r[0]   <= dmag;
      ovf_r[0] <= mi3_pkg::DmagW'(nmag[mi3_pkg::NmagW-1:8]) >= dmag;
      neg_r[0] <= adj_in[mi3_pkg::AdjW-1] ^ det_in[mi3_pkg::DetW-1];
      for (int k = 1; k <= Q; k++) begin
        rem_r[k] <= rem_nxt[k];
        nlo_r[k] <= {nlo_r[k-1][Q-2:0], 1'b0};
        quo_r[k] <= quo_nxt[k];
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign res.quo = quo_r[Q];
  assign res.ovf = ovf_r[Q];
  assign res.neg = neg_r[Q];

endmodule

[design/mi3_merge.sv]
// Merge stage: signs, saturates or zeroes lane results, packs det; holds the output skid pair.
`timescale 1ns / 1ps
module mi3_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_in,
  input  mi3_pkg::lane_res_t               lane_in[mi3_pkg::NumElem],
  input  mi3_pkg::det_t                    det_in,
  output logic                             en,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mi3_pkg::OutTdataW-1:0]    out_tdata,
  output logic                             out_tuser
);

  localparam int Q = mi3_pkg::QuoW;

  logic [mi3_pkg::OutTdataW-1:0] word;
  logic                          sing;
  logic [Q-1:0]                  ent;
  logic                          push;

  logic                          out_vld_r, out_vld_nxt;
  logic [mi3_pkg::OutTdataW-1:0] out_dat_r, out_dat_nxt;
  logic                          out_sng_r, out_sng_nxt;
  logic                          skd_vld_r, skd_vld_nxt;
  logic [mi3_pkg::OutTdataW-1:0] skd_dat_r, skd_dat_nxt;
  logic                          skd_sng_r, skd_sng_nxt;

  always_comb begin
    sing = (det_in == '0);
    word = '0;
    for (int k = 0; k < mi3_pkg::NumElem; k++) begin
      if (sing) begin
        ent = '0;
      end else if (lane_in[k].ovf || lane_in[k].quo[Q-1]) begin
        ent = lane_in[k].neg ? {1'b1, {(Q-1){1'b0}}} : {1'b0, {(Q-1){1'b1}}};
      end else begin
        ent = lane_in[k].neg ? -lane_in[k].quo : lane_in[k].quo;
      end
      word[k*Q +: Q] = ent;
    end
    word[mi3_pkg::NumElem*Q +: mi3_pkg::DetW] = det_in;
  end

  assign en   = !skd_vld_r;
  assign push = vld_in && en;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    out_sng_nxt = out_sng_r;
    skd_vld_nxt = skd_vld_r;
    skd_dat_nxt = skd_dat_r;
    skd_sng_nxt = skd_sng_r;
    if (!out_vld_r || out_tready) begin
      if (skd_vld_r) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = skd_dat_r;
        out_sng_nxt = skd_sng_r;
        skd_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_dat_nxt = word;
        out_sng_nxt = sing;
      end
    end else if (push) begin
      skd_vld_nxt = 1'b1;
      skd_dat_nxt = word;
      skd_sng_nxt = sing;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skd_vld_r <= skd_vld_nxt;
    end
    out_dat_r <= out_dat_nxt;
    out_sng_r <= out_sng_nxt;
    skd_dat_r <= skd_dat_nxt;
    skd_sng_r <= skd_sng_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign out_tuser  = out_sng_r;

endmodule
